/* design/mvm_pkg.sv */
package mvm_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 64;

    localparam int ROW_W       = 4;
    localparam int COL_W       = 6;
    localparam int VALUE_W     = 16;
    localparam int COLS_CFG_W  = 7;
    localparam int ROWS_CFG_W  = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_IDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int MEM_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int MEM_ADDR_W  = $clog2(MEM_DEPTH);

    localparam int PROD_W      = 2 * VALUE_W;
    localparam int ACC_W       = 40;
    localparam int FRAC_SHIFT  = 14;
    localparam int SHIFTED_W   = ACC_W - FRAC_SHIFT;
    localparam int OUT_W       = 24;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IDX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX = 1'd1;

    localparam logic CMD_WEIGHT  = 1'b0;
    localparam logic CMD_ELEMENT = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_MAC,
        OP_CLOSE
    } op_kind_t;

    typedef struct packed {
        logic                      cmd;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row_index;
        logic signed [OUT_W-1:0]   out_value;
        logic                      saturated;
        logic                      last_row;
    } out_item_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [ROW_IDX_W-1:0]      row;
        logic [COL_IDX_W-1:0]      col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [ROWS_CNT_W-1:0]     nrows;
    } op_t;

endpackage

/* design/matrix_vector_multiply_core.sv */
// channel  | signals                         | transfer when
// ---------+---------------------------------+------------------------------------
// input    | in_valid, in_ready, in_data     | in_valid && in_ready at clk rise
// result   | out_valid, out_ready, out_data  | out_valid && out_ready at clk rise
// config   | cfg_we, cfg_index, cfg_data     | cfg_we at clk rise, no wait
//
// Weight write: a single write to the weight memory.
// Vector element: dequeue, one weight read per active row, then multiply, accumulate
// and the drain check before the next dequeue.
// The last element then sends one result per active row through the result register.
// A two-entry queue keeps input transfers going while the back end works; a stalled
// result holds the emit sequence. Reset clears the accumulators, not the weights.
module matrix_vector_multiply_core import mvm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic push_valid;
    logic push_ready;
    op_t  push_op;
    logic pop_valid;
    logic pop_ready;
    op_t  pop_op;

    mvm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    mvm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    mvm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* design/mvm_front.sv */
module mvm_front import mvm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output op_t                   push_op
);

    logic [COLS_CFG_W-1:0] cols_in_use_reg;
    logic [ROWS_CFG_W-1:0] rows_in_use_reg;
    logic [ROWS_CNT_W-1:0] nrows;
    logic                  wr_in_range;
    logic                  col_active;
    logic                  keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg <= COLS_CFG_W'(MAX_COLS);
            rows_in_use_reg <= ROWS_CFG_W'(MAX_ROWS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLS_IDX: cols_in_use_reg <= cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS_IDX: rows_in_use_reg <= cfg_data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(rows_in_use_reg) > MAX_ROWS)
            nrows = ROWS_CNT_W'(MAX_ROWS);
        else
            nrows = ROWS_CNT_W'(rows_in_use_reg);

        wr_in_range = (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
        col_active  = (32'(in_data.col) < 32'(cols_in_use_reg)) &&
                      (32'(in_data.col) < MAX_COLS);

        push_op       = '0;
        push_op.row   = ROW_IDX_W'(in_data.row);
        push_op.col   = COL_IDX_W'(in_data.col);
        push_op.value = in_data.value;
        push_op.nrows = nrows;

        if (in_data.cmd == CMD_WEIGHT)
        begin
            push_op.kind = OP_WRITE;
            push_op.last = 1'b0;
            keep         = wr_in_range;
        end
        else
        begin
            push_op.kind = col_active ? OP_MAC : OP_CLOSE;
            push_op.last = in_data.last;
            keep         = col_active || in_data.last;
        end
    end

    // drop transfers that change nothing
    assign in_ready   = push_ready;
    assign push_valid = in_valid && keep;

endmodule

/* design/mvm_queue.sv */
module mvm_queue import mvm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (32'(count_reg) < QUEUE_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 :
                              wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 :
                              rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* design/mvm_back.sv */
module mvm_back import mvm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  op_t       pop_op,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } state_t;

    logic signed [VALUE_W-1:0] weight_mem [MEM_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    state_t                    state_reg,     state_next;
    op_t                       cur_reg,       cur_next;
    logic [ROWS_CNT_W-1:0]     issue_row_reg, issue_row_next;
    logic                      s1_valid_reg,  s1_valid_next;
    logic [ROW_IDX_W-1:0]      s1_row_reg,    s1_row_next;
    logic                      s2_valid_reg,  s2_valid_next;
    logic [ROW_IDX_W-1:0]      s2_row_reg,    s2_row_next;
    logic signed [PROD_W-1:0]  prod_reg,      prod_next;
    logic [ROWS_CNT_W-1:0]     emit_row_reg,  emit_row_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg,       out_next;
    logic signed [ACC_W-1:0]   acc_reg [MAX_ROWS];

    logic                      mem_we;
    logic [MEM_ADDR_W-1:0]     mem_wr_addr;
    logic [MEM_ADDR_W-1:0]     mem_rd_addr;
    logic                      acc_clear;
    logic signed [ACC_W-1:0]   acc_sel;
    logic signed [SHIFTED_W-1:0] shifted;
    logic                      fits;
    logic                      out_free;
    logic                      last_emit;

    assign mem_wr_addr = MEM_ADDR_W'(pop_op.row) * MEM_ADDR_W'(MAX_COLS) +
                         MEM_ADDR_W'(pop_op.col);
    assign mem_rd_addr = MEM_ADDR_W'(issue_row_reg[ROW_IDX_W-1:0]) *
                         MEM_ADDR_W'(MAX_COLS) + MEM_ADDR_W'(cur_reg.col);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            weight_mem[mem_wr_addr] <= pop_op.value;
        rd_data_reg <= weight_mem[mem_rd_addr];
    end

    assign acc_sel   = acc_reg[emit_row_reg[ROW_IDX_W-1:0]];
    assign shifted   = SHIFTED_W'(acc_sel >>> FRAC_SHIFT);
    assign fits      = (shifted[SHIFTED_W-1:OUT_W-1] == '0) ||
                       (shifted[SHIFTED_W-1:OUT_W-1] == '1);
    assign out_free  = !out_valid_reg || out_ready;
    assign last_emit = (emit_row_reg == cur_reg.nrows - ROWS_CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        issue_row_next = issue_row_reg;
        s1_valid_next  = 1'b0;
        s1_row_next    = s1_row_reg;
        s2_valid_next  = s1_valid_reg;
        s2_row_next    = s1_row_reg;
        prod_next      = PROD_W'(rd_data_reg) * PROD_W'(cur_reg.value);
        emit_row_next  = emit_row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        pop_ready      = 1'b0;
        mem_we         = 1'b0;
        acc_clear      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    if (pop_op.kind == OP_WRITE)
                        mem_we = 1'b1;
                    else
                    begin
                        cur_next       = pop_op;
                        issue_row_next = '0;
                        if (pop_op.kind == OP_MAC && pop_op.nrows != '0)
                            state_next = S_MAC;
                        else
                            state_next = S_DRAIN;
                    end
                end
            end

            S_MAC:
            begin
                s1_valid_next  = 1'b1;
                s1_row_next    = issue_row_reg[ROW_IDX_W-1:0];
                issue_row_next = issue_row_reg + ROWS_CNT_W'(1);
                if (issue_row_reg == cur_reg.nrows - ROWS_CNT_W'(1))
                    state_next = S_DRAIN;
            end

            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    emit_row_next = '0;
                    if (!cur_reg.last)
                        state_next = S_IDLE;
                    else if (cur_reg.nrows == '0)
                    begin
                        acc_clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.row_index = ROW_W'(emit_row_reg);
                    out_next.saturated = !fits;
                    out_next.last_row  = last_emit;
                    if (fits)
                        out_next.out_value = shifted[OUT_W-1:0];
                    else if (shifted[SHIFTED_W-1])
                        out_next.out_value = OUT_MIN;
                    else
                        out_next.out_value = OUT_MAX;
                    emit_row_next = emit_row_reg + ROWS_CNT_W'(1);
                    if (last_emit)
                    begin
                        acc_clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            issue_row_reg <= '0;
            emit_row_reg  <= '0;
            for (int i = 0; i < MAX_ROWS; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            issue_row_reg <= issue_row_next;
            emit_row_reg  <= emit_row_next;
            if (acc_clear)
            begin
                for (int i = 0; i < MAX_ROWS; i++)
                    acc_reg[i] <= '0;
            end
            else if (s2_valid_reg)
                acc_reg[s2_row_reg] <= acc_reg[s2_row_reg] + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        s1_row_reg <= s1_row_next;
        s2_row_reg <= s2_row_next;
        prod_reg   <= prod_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* design/mvm_checker.sv */
module mvm_checker import mvm_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.out_value == OUT_MAX) || (out_data.out_value == OUT_MIN))
        else $error("saturated result not at a range limit");

    a_top_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(out_data.row_index) == MAX_ROWS - 1) |-> out_data.last_row)
        else $error("top row result not flagged last");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
